### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; they compile to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define DHV_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dhv: assertion failed");
// Next-cycle implication, disabled during reset.
`define DHV_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dhv: assertion failed");
`else
`define DHV_ASSERT_IMP(name, clk, rst, ante, cons)
`define DHV_ASSERT_NXT(name, clk, rst, ante, cons)
`endif
`endif

### hw/rtl/dhv_pkg.sv
// ----------------------------------------------------------------------------
// dhv_pkg
// Types, character codes and verdict codes of the host name validator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dhv_pkg;

   localparam int CharW      = 16;
   localparam int NameLenW   = 9;
   localparam int LabelLenW  = 7;
   localparam int VerdictW   = 3;
   localparam int CsrIndexW  = 4;
   localparam int CsrDataW   = 16;

   localparam logic [NameLenW-1:0]  NAME_LIMIT_RESET  = 9'd253;
   localparam logic [LabelLenW-1:0] LABEL_LIMIT_RESET = 7'd63;

   // Register indexes on the configuration channel.
   localparam logic [CsrIndexW-1:0] CSR_NAME_LIMIT  = 4'd0;
   localparam logic [CsrIndexW-1:0] CSR_LABEL_LIMIT = 4'd1;

   // Verdict codes.
   localparam logic [VerdictW-1:0] VERDICT_PENDING    = 3'd0;
   localparam logic [VerdictW-1:0] VERDICT_ACCEPT     = 3'd1;
   localparam logic [VerdictW-1:0] VERDICT_BAD_CHAR   = 3'd2;
   localparam logic [VerdictW-1:0] VERDICT_EMPTY      = 3'd3;
   localparam logic [VerdictW-1:0] VERDICT_LABEL_LONG = 3'd4;
   localparam logic [VerdictW-1:0] VERDICT_HYPHEN     = 3'd5;
   localparam logic [VerdictW-1:0] VERDICT_NAME_LONG  = 3'd6;
   localparam logic [VerdictW-1:0] VERDICT_DOT_EDGE   = 3'd7;

   // Character codes.
   localparam logic [CharW-1:0] CHAR_DOT      = 16'h002E;
   localparam logic [CharW-1:0] CHAR_HYPHEN   = 16'h002D;
   localparam logic [CharW-1:0] CHAR_UPPER_A  = 16'h0041;
   localparam logic [CharW-1:0] CHAR_UPPER_Z  = 16'h005A;
   localparam logic [CharW-1:0] CHAR_LOWER_A  = 16'h0061;
   localparam logic [CharW-1:0] CHAR_LOWER_Z  = 16'h007A;
   localparam logic [CharW-1:0] CHAR_DIGIT_0  = 16'h0030;
   localparam logic [CharW-1:0] CHAR_DIGIT_9  = 16'h0039;
   localparam logic [CharW-1:0] CASE_OFFSET   = 16'h0020;

   typedef struct packed {
      logic [CharW-1:0] char_code;
      logic             end_of_name;
   } req_item_type;

   typedef struct packed {
      logic [CharW-1:0]    lowered_char;
      logic                name_done;
      logic [VerdictW-1:0] verdict;
   } rsp_item_type;

   typedef struct packed {
      logic [NameLenW-1:0]  name_limit;
      logic [LabelLenW-1:0] label_limit;
   } limits_type;

   function automatic logic is_upper(input logic [CharW-1:0] ch);
      return (ch >= CHAR_UPPER_A) && (ch <= CHAR_UPPER_Z);
   endfunction

endpackage

### hw/rtl/dhv_channels.sv
// ----------------------------------------------------------------------------
// dhv channels
// Valid/ready channel interfaces for characters, results and register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dhv_req_if;
   logic                       valid;
   logic                       ready;
   logic [dhv_pkg::CharW-1:0]  char_code;
   logic                       end_of_name;

   modport source (output valid, output char_code, output end_of_name, input ready);
   modport sink   (input valid, input char_code, input end_of_name, output ready);
endinterface

interface dhv_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [dhv_pkg::CharW-1:0]    lowered_char;
   logic                         name_done;
   logic [dhv_pkg::VerdictW-1:0] verdict;

   modport source (output valid, output lowered_char, output name_done,
                   output verdict, input ready);
   modport sink   (input valid, input lowered_char, input name_done,
                   input verdict, output ready);
endinterface

interface dhv_csr_if;
   logic                          valid;
   logic                          ready;
   logic [dhv_pkg::CsrIndexW-1:0] index;
   logic [dhv_pkg::CsrDataW-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/dns_hostname_validator.sv
// ----------------------------------------------------------------------------
// dns_hostname_validator
// Streaming host name checker: folds case and validates LDH labels.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one UTF-16 character beat with end_of_name set on the
//   last character of a name. rsp_chan returns one beat per character: the
//   character with A-Z folded to lower case, name_done copied from
//   end_of_name, and a verdict. Mid-name beats show the first fault seen so
//   far (0 while clean); the last beat shows accepted or the error code.
//   csr_chan writes name_limit (index 0) and label_limit (index 1); other
//   indexes are ignored. It is always ready and must only be used while no
//   name is in flight.
//   An accepted character waits in the input register, then the check runs
//   in one pass into the result register. One character is accepted per
//   cycle as long as the receiver keeps taking results.
//   Reset clears both pipeline registers and the per-name state and loads
//   the limits with 253 and 63. When rsp_chan stalls, the result register
//   holds its beat and the input register can still take one more
//   character before req_chan ready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dns_hostname_validator (
   input  logic      clock,
   input  logic      reset,
   dhv_req_if.sink   req_chan,
   dhv_rsp_if.source rsp_chan,
   dhv_csr_if.sink   csr_chan
);

   dhv_pkg::req_item_type req_item, in_item;
   dhv_pkg::rsp_item_type scan_result, out_item;
   dhv_pkg::limits_type   limits;
   logic                  in_valid, out_valid, out_free, advance, req_fire;

   logic [dhv_pkg::NameLenW-1:0]  name_limit_ff;
   logic [dhv_pkg::LabelLenW-1:0] label_limit_ff;

   // Configuration registers; writes complete in the cycle they are offered.
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         name_limit_ff  <= dhv_pkg::NAME_LIMIT_RESET;
         label_limit_ff <= dhv_pkg::LABEL_LIMIT_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            dhv_pkg::CSR_NAME_LIMIT: begin
               name_limit_ff <= csr_chan.data[dhv_pkg::NameLenW-1:0];
            end
            dhv_pkg::CSR_LABEL_LIMIT: begin
               label_limit_ff <= csr_chan.data[dhv_pkg::LabelLenW-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign limits.name_limit  = name_limit_ff;
   assign limits.label_limit = label_limit_ff;

   // Pipeline handshake. The scan steps when the input register holds a
   // character and the result register is empty or being emptied.
   assign out_free       = !out_valid || rsp_chan.ready;
   assign advance        = in_valid && out_free;
   assign req_chan.ready = !in_valid || advance;
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign req_item.char_code   = req_chan.char_code;
   assign req_item.end_of_name = req_chan.end_of_name;

   dhv_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (req_fire),
      .load_item  (req_item),
      .advance    (advance),
      .item_valid (in_valid),
      .item       (in_item)
   );

   dhv_scan u_scan (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item),
      .limits (limits),
      .result (scan_result)
   );

   dhv_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .load_item  (scan_result),
      .taken      (rsp_chan.ready),
      .item_valid (out_valid),
      .item       (out_item)
   );

   assign rsp_chan.valid        = out_valid;
   assign rsp_chan.lowered_char = out_item.lowered_char;
   assign rsp_chan.name_done    = out_item.name_done;
   assign rsp_chan.verdict      = out_item.verdict;

   // The scan never overwrites a result the receiver has not taken.
   `DHV_ASSERT_IMP(a_no_overwrite, clock, reset, advance, out_free)
   // Only a final beat may carry acceptance, and a final beat is never pending.
   `DHV_ASSERT_IMP(a_accept_final, clock, reset,
                   out_valid && (out_item.verdict == dhv_pkg::VERDICT_ACCEPT),
                   out_item.name_done)
   `DHV_ASSERT_IMP(a_final_decided, clock, reset,
                   out_valid && out_item.name_done,
                   out_item.verdict != dhv_pkg::VERDICT_PENDING)
   // A stepped character always lands in the result register next cycle.
   `DHV_ASSERT_NXT(a_step_lands, clock, reset, advance, out_valid)

endmodule

### hw/rtl/dhv_in_reg.sv
// ----------------------------------------------------------------------------
// dhv_in_reg
// Input register: holds one accepted character beat until the scan takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dhv_in_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  dhv_pkg::req_item_type load_item,
   input  logic                  advance,
   output logic                  item_valid,
   output dhv_pkg::req_item_type item
);

   logic                  valid_ff, valid_in;
   dhv_pkg::req_item_type item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= load_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

### hw/rtl/dhv_scan.sv
// ----------------------------------------------------------------------------
// dhv_scan
// Per-name scan state and the single-pass check of one character.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dhv_scan (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  dhv_pkg::req_item_type item,
   input  dhv_pkg::limits_type   limits,
   output dhv_pkg::rsp_item_type result
);

   logic [dhv_pkg::NameLenW-1:0]  name_length_ff, name_length_in;
   logic                          overflow_ff, overflow_in;
   logic [dhv_pkg::LabelLenW-1:0] label_length_ff, label_length_in;
   logic                          starts_hyphen_ff, starts_hyphen_in;
   logic                          prev_hyphen_ff, prev_hyphen_in;
   logic [dhv_pkg::VerdictW-1:0]  fault_ff, fault_in;
   logic                          starts_dot_ff, starts_dot_in;

   logic [dhv_pkg::CharW-1:0]     low;
   logic                          first, is_dot, is_hyphen, char_ok, last;
   logic [dhv_pkg::NameLenW:0]    new_name;
   logic [dhv_pkg::LabelLenW:0]   new_label;
   logic                          label_long, name_long;
   logic [dhv_pkg::VerdictW-1:0]  verdict;

   always_comb begin
      last      = item.end_of_name;
      low       = dhv_pkg::is_upper(item.char_code)
                  ? item.char_code + dhv_pkg::CASE_OFFSET : item.char_code;
      is_dot    = (item.char_code == dhv_pkg::CHAR_DOT);
      is_hyphen = (low == dhv_pkg::CHAR_HYPHEN);
      char_ok   = ((low >= dhv_pkg::CHAR_LOWER_A) && (low <= dhv_pkg::CHAR_LOWER_Z))
                  || ((low >= dhv_pkg::CHAR_DIGIT_0) && (low <= dhv_pkg::CHAR_DIGIT_9))
                  || is_hyphen;
      first     = (name_length_ff == '0) && !overflow_ff;

      new_name       = {1'b0, name_length_ff} + 1'b1;
      overflow_in    = overflow_ff | (&name_length_ff);
      name_length_in = (&name_length_ff) ? name_length_ff
                                         : new_name[dhv_pkg::NameLenW-1:0];

      new_label  = {1'b0, label_length_ff} + 1'b1;
      label_long = (new_label > {1'b0, limits.label_limit});

      fault_in         = fault_ff;
      starts_dot_in    = starts_dot_ff;
      label_length_in  = '0;
      starts_hyphen_in = 1'b0;
      prev_hyphen_in   = 1'b0;

      if (is_dot) begin
         // A dot closes the current label; a dot as the first character of a name is an edge.
         if (first) begin
            starts_dot_in = 1'b1;
         end else if (label_length_ff == '0) begin
            if (fault_in == dhv_pkg::VERDICT_PENDING) fault_in = dhv_pkg::VERDICT_EMPTY;
         end else if (starts_hyphen_ff || prev_hyphen_ff) begin
            if (fault_in == dhv_pkg::VERDICT_PENDING) fault_in = dhv_pkg::VERDICT_HYPHEN;
         end
      end else begin
         if (!char_ok && (fault_in == dhv_pkg::VERDICT_PENDING)) begin
            fault_in = dhv_pkg::VERDICT_BAD_CHAR;
         end
         if (label_long && (fault_in == dhv_pkg::VERDICT_PENDING)) begin
            fault_in = dhv_pkg::VERDICT_LABEL_LONG;
         end
         starts_hyphen_in = (label_length_ff == '0) ? is_hyphen : starts_hyphen_ff;
         prev_hyphen_in   = is_hyphen;
         label_length_in  = new_label[dhv_pkg::LabelLenW] ? '1
                            : new_label[dhv_pkg::LabelLenW-1:0];
         if (last && (starts_hyphen_in || prev_hyphen_in)
             && (fault_in == dhv_pkg::VERDICT_PENDING)) begin
            fault_in = dhv_pkg::VERDICT_HYPHEN;
         end
      end

      name_long = overflow_in || (new_name > {1'b0, limits.name_limit});

      if (last) begin
         priority if (name_long) begin
            verdict = dhv_pkg::VERDICT_NAME_LONG;
         end else if (starts_dot_in || is_dot) begin
            verdict = dhv_pkg::VERDICT_DOT_EDGE;
         end else if (fault_in != dhv_pkg::VERDICT_PENDING) begin
            verdict = fault_in;
         end else begin
            verdict = dhv_pkg::VERDICT_ACCEPT;
         end
      end else begin
         verdict = fault_in;
      end

      result.lowered_char = low;
      result.name_done    = last;
      result.verdict      = verdict;
   end

   always_ff @(posedge clock) begin
      if (reset || (step && item.end_of_name)) begin
         name_length_ff   <= '0;
         overflow_ff      <= 1'b0;
         label_length_ff  <= '0;
         starts_hyphen_ff <= 1'b0;
         prev_hyphen_ff   <= 1'b0;
         fault_ff         <= dhv_pkg::VERDICT_PENDING;
         starts_dot_ff    <= 1'b0;
      end else if (step) begin
         name_length_ff   <= name_length_in;
         overflow_ff      <= overflow_in;
         label_length_ff  <= label_length_in;
         starts_hyphen_ff <= starts_hyphen_in;
         prev_hyphen_ff   <= prev_hyphen_in;
         fault_ff         <= fault_in;
         starts_dot_ff    <= starts_dot_in;
      end
   end

endmodule

### hw/rtl/dhv_out_reg.sv
// ----------------------------------------------------------------------------
// dhv_out_reg
// Result register: holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dhv_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  dhv_pkg::rsp_item_type load_item,
   input  logic                  taken,
   output logic                  item_valid,
   output dhv_pkg::rsp_item_type item
);

   logic                  valid_ff, valid_in;
   dhv_pkg::rsp_item_type item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (taken) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= load_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

### tb/hostname_verdict_check.sv
// ----------------------------------------------------------------------------
// hostname_verdict_check
// Watches the character, result and register channels of the host name
// validator, predicts each result beat and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hostname_verdict_check
   import dhv_pkg::*;
(
   input  logic clock,
   input  logic reset,
   dhv_req_if   req_mon,
   dhv_rsp_if   rsp_mon,
   dhv_csr_if   csr_mon,
   output int   fail_count,
   output int   pending
);

   logic [NameLenW-1:0]  name_limit;
   logic [LabelLenW-1:0] label_limit;

   logic [NameLenW-1:0]  name_len;
   logic                 name_ovf;
   logic [LabelLenW-1:0] label_len;
   logic                 lead_hyphen;
   logic                 last_hyphen;
   logic [VerdictW-1:0]  first_fault;
   logic                 lead_dot;

   rsp_item_type expected_q[$];

   task automatic report_mismatch(input string msg);
      $display("[%0t] host name check: %s", $time, msg);
      fail_count++;
   endtask

   function automatic void clear_name();
      name_len    = '0;
      name_ovf    = 1'b0;
      label_len   = '0;
      lead_hyphen = 1'b0;
      last_hyphen = 1'b0;
      first_fault = VERDICT_PENDING;
      lead_dot    = 1'b0;
   endfunction

   function automatic void note_fault(input logic [VerdictW-1:0] code);
      if (first_fault == VERDICT_PENDING) begin
         first_fault = code;
      end
   endfunction

   // Folds the character, advances the per-name state and returns the beat
   // the block should send for it.
   function automatic rsp_item_type judge_char(input logic [CharW-1:0] ch,
                                               input logic last);
      rsp_item_type r;
      logic [CharW-1:0] low;
      logic first, is_dot, hy, ok;
      logic [NameLenW:0] grown_name;
      logic [LabelLenW:0] grown_label;

      first  = (name_len == '0) && !name_ovf;
      is_dot = (ch == CHAR_DOT);
      low    = ch;
      if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) begin
         low = ch + CASE_OFFSET;
      end

      grown_name = {1'b0, name_len} + 1'b1;
      if (name_len == '1) begin
         name_ovf = 1'b1;
      end
      name_len = grown_name[NameLenW] ? '1 : grown_name[NameLenW-1:0];

      if (is_dot) begin
         if (first) begin
            lead_dot = 1'b1;
         end else if (label_len == '0) begin
            note_fault(VERDICT_EMPTY);
         end else if (lead_hyphen || last_hyphen) begin
            note_fault(VERDICT_HYPHEN);
         end
         label_len   = '0;
         lead_hyphen = 1'b0;
         last_hyphen = 1'b0;
      end else begin
         hy = (low == CHAR_HYPHEN);
         ok = (low >= CHAR_LOWER_A && low <= CHAR_LOWER_Z) ||
              (low >= CHAR_DIGIT_0 && low <= CHAR_DIGIT_9) || hy;
         grown_label = {1'b0, label_len} + 1'b1;
         if (!ok) begin
            note_fault(VERDICT_BAD_CHAR);
         end
         if (label_len == '0) begin
            lead_hyphen = hy;
         end
         if (grown_label > label_limit) begin
            note_fault(VERDICT_LABEL_LONG);
         end
         label_len   = grown_label[LabelLenW] ? '1 : grown_label[LabelLenW-1:0];
         last_hyphen = hy;
         if (last && (lead_hyphen || last_hyphen)) begin
            note_fault(VERDICT_HYPHEN);
         end
      end

      r.lowered_char = low;
      r.name_done    = last;
      if (last) begin
         if (name_ovf || grown_name > name_limit) begin
            r.verdict = VERDICT_NAME_LONG;
         end else if (lead_dot || is_dot) begin
            r.verdict = VERDICT_DOT_EDGE;
         end else if (first_fault != VERDICT_PENDING) begin
            r.verdict = first_fault;
         end else begin
            r.verdict = VERDICT_ACCEPT;
         end
         clear_name();
      end else begin
         r.verdict = first_fault;
      end
      return r;
   endfunction

   always @(posedge clock) begin : watch
      rsp_item_type want;
      if (reset) begin
         name_limit  = NAME_LIMIT_RESET;
         label_limit = LABEL_LIMIT_RESET;
         fail_count  = 0;
         clear_name();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            if (csr_mon.index == CSR_NAME_LIMIT) begin
               name_limit = csr_mon.data[NameLenW-1:0];
            end else if (csr_mon.index == CSR_LABEL_LIMIT) begin
               label_limit = csr_mon.data[LabelLenW-1:0];
            end
         end
         // Compare before queuing, so a character never meets its own result.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_q.size() == 0) begin
               report_mismatch($sformatf("result beat 0x%04h with nothing expected",
                                         rsp_mon.lowered_char));
            end else begin
               want = expected_q.pop_front();
               if (rsp_mon.lowered_char !== want.lowered_char) begin
                  report_mismatch($sformatf("lowered_char 0x%04h, expected 0x%04h",
                                            rsp_mon.lowered_char, want.lowered_char));
               end
               if (rsp_mon.name_done !== want.name_done) begin
                  report_mismatch($sformatf("name_done %b, expected %b",
                                            rsp_mon.name_done, want.name_done));
               end
               if (rsp_mon.verdict !== want.verdict) begin
                  report_mismatch($sformatf("verdict %0d, expected %0d (char 0x%04h)",
                                            rsp_mon.verdict, want.verdict,
                                            want.lowered_char));
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_q.insert(expected_q.size(),
                              judge_char(req_mon.char_code, req_mon.end_of_name));
         end
      end
      pending = expected_q.size();
   end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Top of the host name validator bench: drives names through the block under
// several limit settings and handshake patterns while a separate checker
// predicts and compares every result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import dhv_pkg::*;

   // Cycles in which no beat moves on any channel before the run is called
   // hung. The longest legitimate quiet stretch is the long receiver stall.
   localparam int IDLE_LIMIT = 3000;
   localparam int LONG_STALL = 300;
   // An index with no register behind it; writes there must change nothing.
   localparam logic [CsrIndexW-1:0] CSR_UNMAPPED = 4'd9;

   logic clock;
   logic reset;

   dhv_req_if req_chan ();
   dhv_rsp_if rsp_chan ();
   dhv_csr_if csr_chan ();

   int fail_count;
   int pending;

   // Percent of cycles in which the sender and the receiver hold back.
   int tx_idle_pct;
   int rx_idle_pct;
   // The stimulus bumps stall_asks to ask the receiver for a long hold-off;
   // the receiver notes each request it has served in stall_seen.
   int stall_asks;
   int stall_seen;
   int stall_left;
   int idle_cycles = 0;
   int sent_count;

   // The bench's own record of the limits it wrote, used to shape names.
   logic [NameLenW-1:0]  cur_name_limit;
   logic [LabelLenW-1:0] cur_label_limit;

   // Characters of the name about to be sent.
   logic [CharW-1:0] name_q[$];

   dns_hostname_validator uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   hostname_verdict_check verdict_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .csr_mon    (csr_chan),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever begin
         #5 clock = ~clock;
      end
   end

   // The receiver. It normally drops ready at random, but when the stimulus
   // asks for a long stall it counts the stall out here, so the sender keeps
   // offering characters while the block fills up.
   initial begin : receiver
      rsp_chan.ready = 1'b0;
      stall_left     = 0;
      stall_seen     = 0;
      forever begin
         @(negedge clock);
         if (stall_asks != stall_seen) begin
            stall_left = LONG_STALL;
            stall_seen = stall_asks;
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
         end
      end
   end

   // Watchdog: any beat on any channel restarts the count.
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          (csr_chan.valid && csr_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offers one character, possibly after some idle cycles, and returns at
   // the rising edge that accepts it. Valid stays high into the next call so
   // back-to-back beats need no gap.
   task automatic send_char(input logic [CharW-1:0] ch, input logic last);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
      end
      @(negedge clock);
      req_chan.valid       <= 1'b1;
      req_chan.char_code   <= ch;
      req_chan.end_of_name <= last;
      do begin
         @(posedge clock);
      end while (!req_chan.ready);
      sent_count++;
   endtask

   // Sends the queued characters as one name and empties the queue.
   task automatic send_name();
      foreach (name_q[i]) begin
         send_char(name_q[i], i == name_q.size() - 1);
      end
      name_q.delete();
   endtask

   // Appends one character to the name being built.
   task automatic add_char(input logic [CharW-1:0] ch);
      name_q.insert(name_q.size(), ch);
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         add_char({8'h00, s[i]});
      end
   endtask

   // A random letter, digit or (away from the label edges) hyphen. Upper
   // case is mixed in so folding is exercised all the time.
   function automatic logic [CharW-1:0] ldh_char(input logic at_edge);
      int pick;
      pick = $urandom_range(0, at_edge ? 8 : 9);
      if (pick < 4) begin
         return CHAR_LOWER_A + 16'($urandom_range(0, 25));
      end else if (pick < 7) begin
         return CHAR_UPPER_A + 16'($urandom_range(0, 25));
      end else if (pick < 9) begin
         return CHAR_DIGIT_0 + 16'($urandom_range(0, 9));
      end
      return CHAR_HYPHEN;
   endfunction

   // Most names are well formed so the checks run all the way to the final
   // verdict; the rest carry one flaw of a random kind at the front, end or a random place.
   task automatic build_random_name();
      int labels;
      int len;
      int flaw;
      labels = $urandom_range(1, 4);
      flaw   = $urandom_range(0, 99);
      for (int l = 0; l < labels; l++) begin
         if (l != 0) begin
            add_char(CHAR_DOT);
         end
         // Now and then a label sits right at the limit or one past it.
         if ($urandom_range(0, 19) == 0) begin
            len = int'(cur_label_limit) + $urandom_range(0, 1);
         end else begin
            len = $urandom_range(1, 10);
         end
         if (len == 0) begin
            len = 1;
         end
         for (int i = 0; i < len; i++) begin
            add_char(ldh_char(i == 0 || i == len - 1));
         end
      end
      if (flaw >= 65 && flaw < 75) begin
         // Any code unit at all; this is what reaches the upper bits.
         name_q[$urandom_range(0, name_q.size() - 1)] = CharW'($urandom_range(0, 65535));
      end else if (flaw < 79 && flaw >= 75) begin
         name_q.push_front(CHAR_HYPHEN);
      end else if (flaw < 83 && flaw >= 79) begin
         add_char(CHAR_HYPHEN);
      end else if (flaw < 87 && flaw >= 83) begin
         name_q.insert($urandom_range(0, name_q.size()), CHAR_HYPHEN);
      end else if (flaw < 91 && flaw >= 87) begin
         name_q.insert($urandom_range(0, name_q.size()), CHAR_DOT);
      end else if (flaw < 95 && flaw >= 91) begin
         name_q.push_front(CHAR_DOT);
      end else if (flaw >= 95) begin
         add_char(CHAR_DOT);
      end
   endtask

   task automatic random_names(input int count);
      int start;
      start = sent_count;
      while (sent_count - start < count) begin
         build_random_name();
         send_name();
      end
   endtask

   task automatic csr_write(input logic [CsrIndexW-1:0] index,
                            input logic [CsrDataW-1:0] data);
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= index;
      csr_chan.data  <= data;
      do begin
         @(posedge clock);
      end while (!csr_chan.ready);
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   // Writes both limits. The unused upper data bits carry random junk that
   // the block must ignore.
   task automatic set_limits(input logic [NameLenW-1:0] name_lim,
                             input logic [LabelLenW-1:0] label_lim);
      logic [CsrDataW-1:0] junk;
      junk = CsrDataW'($urandom());
      csr_write(CSR_NAME_LIMIT, {junk[CsrDataW-1:NameLenW], name_lim});
      junk = CsrDataW'($urandom());
      csr_write(CSR_LABEL_LIMIT, {junk[CsrDataW-1:LabelLenW], label_lim});
      cur_name_limit  = name_lim;
      cur_label_limit = label_lim;
   endtask

   // The sender stops and waits until every result is back, then lets the
   // two-stage pipeline settle.
   task automatic wait_for_drain();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending != 0) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
   endtask

   initial begin : stimulus
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.char_code   = '0;
      req_chan.end_of_name = 1'b0;
      csr_chan.valid       = 1'b0;
      csr_chan.index       = CSR_NAME_LIMIT;
      csr_chan.data        = '0;
      tx_idle_pct          = 8;
      rx_idle_pct          = 87;
      stall_asks           = 0;
      sent_count           = 0;
      cur_name_limit       = NAME_LIMIT_RESET;
      cur_label_limit      = LABEL_LIMIT_RESET;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed names at the reset limits: a clean single letter, folding,
      // a dot at either edge, an empty label, hyphens at a label's start and
      // end, the extremes of the code unit range, and a lone dot.
      push_text("a");    send_name();
      push_text("Az-9"); send_name();
      push_text(".a");   send_name();
      push_text("a.");   send_name();
      push_text("a..b"); send_name();
      push_text("-a");   send_name();
      push_text("a-.b"); send_name();
      push_text("a");
      add_char(16'hFFFF);
      send_name();
      add_char(16'h0000);
      send_name();
      push_text(".");    send_name();
      push_text("b-");   send_name();

      // The receiver goes quiet for a long while as random names keep
      // coming, so the block fills and has to hold its input.
      stall_asks++;
      random_names(50);
      wait_for_drain();

      // Widest limits. One name runs past the name length counter's top and
      // one label past the label counter's top.
      set_limits('1, '1);
      for (int i = 0; i < 515; i++) begin
         add_char((i % 100 == 99) ? CHAR_DOT : ldh_char(1'b1));
      end
      send_name();
      for (int i = 0; i < 130; i++) begin
         add_char(ldh_char(1'b1));
      end
      push_text(".b");
      send_name();

      // Now the sender is the slow side.
      tx_idle_pct = 87;
      rx_idle_pct = 8;
      random_names(40);
      wait_for_drain();

      // Smallest legal limits: only single-character names get through.
      set_limits(9'd1, 7'd1);
      random_names(15);
      wait_for_drain();

      // Zero limits reject every name; a write to an unmapped index must
      // leave them alone.
      set_limits('0, '0);
      csr_write(CSR_UNMAPPED, 16'hFFFF);
      random_names(15);
      wait_for_drain();

      // Neither side holds back from here on.
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      set_limits(9'd20, 7'd5);
      random_names(25);
      wait_for_drain();

      set_limits(9'd300, 7'd40);
      random_names(25);
      wait_for_drain();

      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
